@@ rtl/core/rotation_to_euler_angles_assert.svh @@
`ifndef ROTATION_TO_EULER_ANGLES_ASSERT_SVH
`define ROTATION_TO_EULER_ANGLES_ASSERT_SVH

// implication checked only outside reset
`define RTEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// property checked at every edge, reset included
`define RTEA_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: unconditional");

`endif

@@ rtl/core/rtea_pkg.sv @@
package rtea_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int DATA_WIDTH    = 16;
  localparam int TAB_LEN       = 24;
  localparam int N_ITER = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  localparam int IN_W   = 16;
  localparam int ANG_W  = 16;
  localparam int ONE_SH = DATA_WIDTH - 2;
  localparam int RND_SH = 32 - DATA_WIDTH;
  localparam int CS_W   = DATA_WIDTH + 3;
  localparam int PW     = IN_W + CS_W;
  localparam int VW     = IN_W + DATA_WIDTH + 6;
  localparam int ROT_W  = 33;

  localparam int VEC_LAT   = N_ITER + 2;
  localparam int ROT_LAT   = N_ITER + 2;
  localparam int TOTAL_LAT = 1 + VEC_LAT + ROT_LAT + 2 + VEC_LAT;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [31:0] PI_BAM   = 32'h8000_0000;
  localparam logic [31:0] HALF_LSB = 32'h0000_8000;
  localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = ROT_W'(652032875);
  localparam logic signed [ROT_W-1:0] ROUND_HALF =
    (RND_SH > 0) ? (ROT_W'(1) <<< (RND_SH - 1)) : '0;

  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r01;
    logic signed [IN_W-1:0] r02;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
    logic signed [IN_W-1:0] r20;
  } rtea_in_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] yaw_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] roll_angle;
  } rtea_out_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/rtea_front.sv @@
module rtea_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rtea_pkg::rtea_in_t in_data,
  output logic              q_vld,
  output rtea_pkg::rtea_in_t q_item
);

  rtea_pkg::rtea_in_t mem_r [0:rtea_pkg::QDEPTH-1];
  logic [rtea_pkg::QPW-1:0] wptr_r, rptr_r;
  logic [rtea_pkg::QCW-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign busy   = (cnt_r == rtea_pkg::QCW'(rtea_pkg::QDEPTH)) || !rst_n;
  assign push   = start && !busy;
  assign pop    = (cnt_r != '0);
  assign q_vld  = pop;
  assign q_item = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
    end
    if (push) mem_r[wptr_r] <= in_data;
  end

endmodule

@@ rtl/core/rtea_cordic_vec.sv @@
module rtea_cordic_vec (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [rtea_pkg::VW-1:0]    x_in,
  input  logic signed [rtea_pkg::VW-1:0]    y_in,
  output logic                              out_vld,
  output logic [rtea_pkg::ANG_W-1:0]        angle
);

  localparam int N = rtea_pkg::N_ITER;

  logic signed [rtea_pkg::VW-1:0] x_r [0:N];
  logic signed [rtea_pkg::VW-1:0] y_r [0:N];
  logic [31:0] z_r [0:N];
  logic        zero_r [0:N];
  logic        vld_r [0:N];
  logic [31:0] z_rnd;
  logic [rtea_pkg::ANG_W-1:0] ang_r;
  logic        out_vld_r;

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= in_vld;
    zero_r[0] <= (x_in == '0) && (y_in == '0);
    if (x_in[rtea_pkg::VW-1]) begin
      x_r[0] <= -x_in;
      y_r[0] <= -y_in;
      z_r[0] <= rtea_pkg::PI_BAM;
    end else begin
      x_r[0] <= x_in;
      y_r[0] <= y_in;
      z_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g+1] <= 1'b0;
      else vld_r[g+1] <= vld_r[g];
      zero_r[g+1] <= zero_r[g];
      if (!y_r[g][rtea_pkg::VW-1]) begin
        x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
        z_r[g+1] <= z_r[g] + rtea_pkg::atan_tab(g);
      end else begin
        x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
        z_r[g+1] <= z_r[g] - rtea_pkg::atan_tab(g);
      end
    end
  end

  assign z_rnd = z_r[N] + rtea_pkg::HALF_LSB;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else out_vld_r <= vld_r[N];
    ang_r <= zero_r[N] ? '0 : z_rnd[31:32-rtea_pkg::ANG_W];
  end

  assign out_vld = out_vld_r;
  assign angle   = ang_r;

endmodule

@@ rtl/core/rtea_cordic_rot.sv @@
module rtea_cordic_rot (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [rtea_pkg::ANG_W-1:0]        code,
  output logic                              out_vld,
  output logic signed [rtea_pkg::CS_W-1:0]  cos_o,
  output logic signed [rtea_pkg::CS_W-1:0]  sin_o
);

  localparam int N  = rtea_pkg::N_ITER;
  localparam int RW = rtea_pkg::ROT_W;

  logic signed [RW-1:0] x_r [0:N];
  logic signed [RW-1:0] y_r [0:N];
  logic signed [RW-1:0] z_r [0:N];
  logic neg_r [0:N];
  logic vld_r [0:N];
  logic [31:0] a_w, a_fold;
  logic        fold;
  logic signed [RW-1:0] xs, ys, xr, yr, xsh, ysh;
  logic signed [rtea_pkg::CS_W-1:0] cos_r, sin_r;
  logic out_vld_r;

  // fold second and third quadrant onto the right half
  assign a_w    = {code, {(32-rtea_pkg::ANG_W){1'b0}}};
  assign fold   = (a_w[31:30] == 2'b01) || (a_w[31:30] == 2'b10);
  assign a_fold = fold ? (a_w + rtea_pkg::PI_BAM) : a_w;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= in_vld;
    neg_r[0] <= fold;
    x_r[0]   <= rtea_pkg::INV_GAIN_Q30;
    y_r[0]   <= '0;
    z_r[0]   <= RW'($signed(a_fold));
  end

  for (genvar g = 0; g < N; g++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g+1] <= 1'b0;
      else vld_r[g+1] <= vld_r[g];
      neg_r[g+1] <= neg_r[g];
      if (!z_r[g][RW-1]) begin
        x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
        z_r[g+1] <= z_r[g] - RW'(rtea_pkg::atan_tab(g));
      end else begin
        x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
        z_r[g+1] <= z_r[g] + RW'(rtea_pkg::atan_tab(g));
      end
    end
  end

  assign xs  = neg_r[N] ? -x_r[N] : x_r[N];
  assign ys  = neg_r[N] ? -y_r[N] : y_r[N];
  assign xr  = xs + rtea_pkg::ROUND_HALF;
  assign yr  = ys + rtea_pkg::ROUND_HALF;
  assign xsh = xr >>> rtea_pkg::RND_SH;
  assign ysh = yr >>> rtea_pkg::RND_SH;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else out_vld_r <= vld_r[N];
    cos_r <= rtea_pkg::CS_W'(xsh);
    sin_r <= rtea_pkg::CS_W'(ysh);
  end

  assign out_vld = out_vld_r;
  assign cos_o   = cos_r;
  assign sin_o   = sin_r;

endmodule

@@ rtl/core/rtea_back.sv @@
module rtea_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  rtea_pkg::rtea_in_t item,
  output logic               out_vld,
  output rtea_pkg::rtea_out_t res
);

  localparam int VW = rtea_pkg::VW;
  localparam int PW = rtea_pkg::PW;
  localparam int ID = rtea_pkg::VEC_LAT + rtea_pkg::ROT_LAT;
  localparam int YD = rtea_pkg::ROT_LAT + 2 + rtea_pkg::VEC_LAT;

  logic signed [VW-1:0] yx, yy;
  logic yaw_vld;
  logic [rtea_pkg::ANG_W-1:0] yaw;
  logic cs_vld;
  logic signed [rtea_pkg::CS_W-1:0] c, s;

  rtea_pkg::rtea_in_t item_dl_r [0:ID-1];
  logic [rtea_pkg::ANG_W-1:0] yaw_dl_r [0:YD-1];
  rtea_pkg::rtea_in_t m;

  logic mul_vld_r, add_vld_r;
  logic signed [PW-1:0] p00c_r, p10s_r, p11c_r, p01s_r, p02s_r, p12c_r;
  logic signed [VW-1:0] nr20_r, py_r, px_r, rx_r, ry_r;

  logic pitch_vld, roll_vld;
  logic [rtea_pkg::ANG_W-1:0] pitch, roll;

  assign yx = VW'(item.r00) <<< rtea_pkg::ONE_SH;
  assign yy = VW'(item.r10) <<< rtea_pkg::ONE_SH;

  rtea_cordic_vec u_yaw (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .x_in(yx), .y_in(yy),
    .out_vld(yaw_vld), .angle(yaw)
  );

  rtea_cordic_rot u_rot (
    .clk(clk), .rst_n(rst_n), .in_vld(yaw_vld), .code(yaw),
    .out_vld(cs_vld), .cos_o(c), .sin_o(s)
  );

  always_ff @(posedge clk) begin
    item_dl_r[0] <= item;
    for (int k = 1; k < ID; k++) item_dl_r[k] <= item_dl_r[k-1];
    yaw_dl_r[0] <= yaw;
    for (int k = 1; k < YD; k++) yaw_dl_r[k] <= yaw_dl_r[k-1];
  end

  assign m = item_dl_r[ID-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      add_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= cs_vld;
      add_vld_r <= mul_vld_r;
    end
    p00c_r <= m.r00 * c;
    p10s_r <= m.r10 * s;
    p11c_r <= m.r11 * c;
    p01s_r <= m.r01 * s;
    p02s_r <= m.r02 * s;
    p12c_r <= m.r12 * c;
    nr20_r <= -(VW'(m.r20) <<< rtea_pkg::ONE_SH);
    px_r   <= VW'(p00c_r) + VW'(p10s_r);
    py_r   <= nr20_r;
    rx_r   <= VW'(p11c_r) - VW'(p01s_r);
    ry_r   <= VW'(p02s_r) - VW'(p12c_r);
  end

  rtea_cordic_vec u_pitch (
    .clk(clk), .rst_n(rst_n), .in_vld(add_vld_r), .x_in(px_r), .y_in(py_r),
    .out_vld(pitch_vld), .angle(pitch)
  );

  rtea_cordic_vec u_roll (
    .clk(clk), .rst_n(rst_n), .in_vld(add_vld_r), .x_in(rx_r), .y_in(ry_r),
    .out_vld(roll_vld), .angle(roll)
  );

  assign out_vld         = pitch_vld && roll_vld;
  assign res.yaw_angle   = yaw_dl_r[YD-1];
  assign res.pitch_angle = pitch;
  assign res.roll_angle  = roll;

endmodule

@@ rtl/core/rotation_to_euler_angles.sv @@
// rotation matrix (seven entries, signed Q1.14) to Z-Y-X euler angles in units
// of pi/32768. one matrix is taken every cycle while busy is low; busy only
// rises in reset. every transaction comes back as a one-cycle out_valid strobe,
// after passing through three chained CORDIC pipelines: yaw vectoring, cos/sin
// rotation of yaw, then pitch and roll vectoring side by side, plus a multiply
// and an add stage. the receiver cannot stall, so results must be taken when
// the strobe shows.
module rotation_to_euler_angles (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rtea_pkg::rtea_in_t  in_data,
  output logic                out_valid,
  output rtea_pkg::rtea_out_t out_data
);

  // queue handoff between front and back
  logic               q_vld;
  rtea_pkg::rtea_in_t q_item;

  // front: accepts transactions into a short queue
  rtea_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .q_vld(q_vld), .q_item(q_item)
  );

  // back: fully pipelined, drains one entry per cycle
  rtea_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(q_vld), .item(q_item),
    .out_vld(out_valid), .res(out_data)
  );

endmodule

@@ rtl/core/rotation_to_euler_angles_chk.sv @@
`include "rotation_to_euler_angles_assert.svh"

module rotation_to_euler_angles_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  localparam int LAT = rtea_pkg::TOTAL_LAT;

  logic acc;
  assign acc = start && !busy;

  `RTEA_ASSERT_IMP(a_acc_gives_result, acc, ##LAT out_valid)
  `RTEA_ASSERT_IMP(a_result_has_cause, out_valid, $past(acc, LAT))
  `RTEA_ASSERT_ALL(a_reset_quiet, !rst_n |=> !out_valid)
  `RTEA_ASSERT_IMP(a_never_full, $past(rst_n), !busy)

endmodule

bind rotation_to_euler_angles rotation_to_euler_angles_chk u_chk (.*);

@@ bench/rotation_to_euler_angles_test.sv @@
module rotation_to_euler_angles_test;
  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point euler predictor, coordinates kept in 64-bit signed integers
  class angle_scoreboard;
    rtea_pkg::rtea_out_t pending_angles[$];
    int mismatches;
    int strays;

    static function logic [31:0] step_angle(int i);
      logic [31:0] t[24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return t[i];
    endfunction

    // atan2(y, x) to a 16-bit binary angle
    static function logic [15:0] vector_angle(longint x, longint y);
      logic [31:0] z;
      logic [31:0] zr;
      longint dx;
      longint dy;
      z = 32'h0;
      if (x == 0 && y == 0) return 16'h0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < rtea_pkg::N_ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += step_angle(i);
        end else begin
          x -= dx;
          y += dy;
          z -= step_angle(i);
        end
      end
      zr = z + 32'h8000;
      return zr[31:16];
    endfunction

    static function longint round_to_data(longint v);
      if (rtea_pkg::RND_SH <= 0) return v;
      return (v + (longint'(1) <<< (rtea_pkg::RND_SH - 1))) >>> rtea_pkg::RND_SH;
    endfunction

    static function void yaw_cos_sin(logic [15:0] code, output longint c,
                                     output longint s);
      logic [31:0] a;
      logic flip;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      a = {code, 16'h0};
      flip = (a[31:30] == 2'd1 || a[31:30] == 2'd2);
      x = 652032875;
      y = 0;
      if (flip) a += 32'h8000_0000;
      z = longint'($signed(a));
      for (int i = 0; i < rtea_pkg::N_ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(step_angle(i));
        end else begin
          x += dx;
          y -= dy;
          z += longint'(step_angle(i));
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = round_to_data(x);
      s = round_to_data(y);
    endfunction

    function void note_matrix(rtea_pkg::rtea_in_t m);
      longint one;
      longint c;
      longint s;
      rtea_pkg::rtea_out_t e;
      one = longint'(1) <<< rtea_pkg::ONE_SH;
      e.yaw_angle = vector_angle(longint'(m.r00) * one, longint'(m.r10) * one);
      yaw_cos_sin(e.yaw_angle, c, s);
      e.pitch_angle = vector_angle(longint'(m.r00) * c + longint'(m.r10) * s,
                                   -longint'(m.r20) * one);
      e.roll_angle = vector_angle(longint'(m.r11) * c - longint'(m.r01) * s,
                                  longint'(m.r02) * s - longint'(m.r12) * c);
      pending_angles.insert(pending_angles.size(), e);
    endfunction

    function void check_angles(rtea_pkg::rtea_out_t got);
      rtea_pkg::rtea_out_t e;
      if (pending_angles.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending_angles.pop_front();
      if (got.yaw_angle !== e.yaw_angle || got.pitch_angle !== e.pitch_angle ||
          got.roll_angle !== e.roll_angle) begin
        mismatches++;
        if (mismatches + strays <= 10)
          $display("angle mismatch: yaw %0d/%0d pitch %0d/%0d roll %0d/%0d",
                   e.yaw_angle, got.yaw_angle, e.pitch_angle, got.pitch_angle,
                   e.roll_angle, got.roll_angle);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20 * rtea_pkg::TOTAL_LAT + 2000;
  localparam int RANDOM_ITEMS = 500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rtea_pkg::rtea_in_t in_data = '0;
  logic out_valid;
  rtea_pkg::rtea_out_t out_data;

  angle_scoreboard board;
  int stall_cycles;
  // sender idles at random before each matrix, except in the steady stretch
  bit steady_burst;

  always #2 clk = ~clk;

  rotation_to_euler_angles dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  // results come as one-cycle strobes, taken at the edge that ends them
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_angles(out_data);
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && !busy && rst_n) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("rotation_to_euler_angles_test failed");
      $finish;
    end
  end

  function automatic logic [15:0] rand_entry();
    // mostly in the nominal range, sometimes any 16-bit code
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'h4000;
      2: return 16'hC000;
      3: return 16'h0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // send one matrix: hold start until the transaction is taken
  task automatic send_matrix(rtea_pkg::rtea_in_t m);
    while (!steady_burst && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_matrix(m);
  endtask

  function automatic rtea_pkg::rtea_in_t diag_matrix(logic [15:0] a, logic [15:0] b,
                                                     logic [15:0] c);
    rtea_pkg::rtea_in_t m;
    m = '0;
    m.r00 = a;
    m.r11 = b;
    m.r20 = c;
    return m;
  endfunction

  function automatic rtea_pkg::rtea_in_t rand_matrix();
    rtea_pkg::rtea_in_t m;
    m.r00 = rand_entry();
    m.r01 = rand_entry();
    m.r02 = rand_entry();
    m.r10 = rand_entry();
    m.r11 = rand_entry();
    m.r12 = rand_entry();
    m.r20 = rand_entry();
    return m;
  endfunction

  initial begin
    rtea_pkg::rtea_in_t m;
    board = new();
    stall_cycles = 0;
    steady_burst = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, all zeros (atan2 of zeros), extremes, quadrants
    send_matrix(diag_matrix(16'h4000, 16'h4000, 16'h0));
    send_matrix('0);
    send_matrix({7{16'h7FFF}});
    send_matrix({7{16'h8000}});
    send_matrix({7{16'hFFFF}});
    send_matrix({7{16'h4000}});
    send_matrix({7{16'hC000}});
    // yaw at exactly +pi, which wraps to -pi
    send_matrix(diag_matrix(16'hC000, 16'hC000, 16'h0));
    // yaw at +-pi/2
    m = '0; m.r10 = 16'h4000; m.r01 = 16'hC000; m.r20 = 16'h4000;
    send_matrix(m);
    m = '0; m.r10 = 16'hC000; m.r01 = 16'h4000; m.r12 = 16'h4000;
    send_matrix(m);
    // pitch at +-pi/2, gimbal lock
    m = '0; m.r20 = 16'hC000; m.r11 = 16'h4000;
    send_matrix(m);
    m = '0; m.r20 = 16'h4000; m.r02 = 16'h4000;
    send_matrix(m);
    send_matrix({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                 16'h5555});
    send_matrix({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                 16'hAAAA});

    // pressure: drain everything before the random part
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_angles.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_burst = (n >= 200 && n < 300);
      send_matrix(rand_matrix());
    end
    start <= 1'b0;

    while (board.pending_angles.size() != 0) @(posedge clk);
    repeat (rtea_pkg::TOTAL_LAT + 10) @(posedge clk);

    if (board.mismatches == 0 && board.strays == 0 &&
        board.pending_angles.size() == 0) begin
      $display("rotation_to_euler_angles_test passed");
    end else begin
      $display("rotation_to_euler_angles_test failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rtea_pkg.sv
rtl/core/rtea_front.sv
rtl/core/rtea_cordic_vec.sv
rtl/core/rtea_cordic_rot.sv
rtl/core/rtea_back.sv
rtl/core/rotation_to_euler_angles.sv
rtl/core/rotation_to_euler_angles_chk.sv
bench/rotation_to_euler_angles_test.sv
